// ----- rtl/m64h_pkg.sv -----
// ----------------------------------------------------------------------------
// m64h_pkg
// Shared constants, codes and types of the 64-bit word stream hash.
// ----------------------------------------------------------------------------
`default_nettype none

package m64h_pkg;

   // hash constants
   localparam logic [63:0] SEED   = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [63:0] FMIX_A = 64'hff51_afd7_ed55_8ccd;
   localparam logic [63:0] FMIX_B = 64'hc4ce_b9fe_1a85_ec53;
   localparam logic [63:0] MUL_K  = 64'h3c79_ac49_2ba7_b653;
   localparam logic [63:0] ADD_K  = 64'h1c69_b3f7_4ac4_ae35;
   localparam int          ROT_N  = 27;
   localparam int          SHR_N  = 33;

   // word geometry
   localparam int                 WORD_BYTES = 8;
   localparam logic [3:0]         FULL_COUNT = 4'd8;

   // default depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // what the back end does with one queued word
   typedef enum logic [1:0] {
      OP_ABSORB,        // mix the word, message continues
      OP_ABSORB_LAST,   // mix the word, then emit the final mix
      OP_FINISH,        // emit the final mix only
      OP_EMPTY          // empty message: emit the bare seed
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        first;
      logic [31:0] length;
      logic [63:0] word;
   } entry_type;

   // request to the shared 64-bit low-product multiplier
   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] product;
   } mul_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/m64h_front.sv -----
// ----------------------------------------------------------------------------
// m64h_front
// Accepts input words, tracks message boundaries, masks short last words
// and classifies each word into a back-end operation.
// ----------------------------------------------------------------------------
`default_nettype none

module m64h_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [63:0]         req_data_word,
   input  wire logic [3:0]          req_byte_count,
   input  wire logic                req_last_word,
   input  wire logic [31:0]         req_message_length,
   output logic                     push_valid,
   input  wire logic                push_ready,
   output m64h_pkg::entry_type      push_entry
);

   logic       in_message_ff;
   logic       in_message_in;
   logic       accept;
   logic       first;
   logic [3:0] count_sat;
   logic [63:0] masked_word;

   assign push_valid = req_valid;
   assign req_ready  = push_ready;
   assign accept     = req_valid && push_ready;
   assign first      = !in_message_ff;

   // saturate the byte count at a full word
   assign count_sat = (req_byte_count > m64h_pkg::FULL_COUNT) ? m64h_pkg::FULL_COUNT
                                                              : req_byte_count;

   // zero unused upper bytes of a short last word
   always_comb begin
      for (int b = 0; b < m64h_pkg::WORD_BYTES; b++) begin
         masked_word[8*b +: 8] = (!req_last_word || (4'(b) < count_sat))
                                 ? req_data_word[8*b +: 8] : 8'h00;
      end
   end

   // classify the word
   always_comb begin
      push_entry.first  = first;
      push_entry.length = req_message_length;
      push_entry.word   = masked_word;
      if (first && req_last_word && (req_message_length == 32'd0)) begin
         push_entry.op = m64h_pkg::OP_EMPTY;
      end else if (!req_last_word) begin
         push_entry.op = m64h_pkg::OP_ABSORB;
      end else if (count_sat != 4'd0) begin
         push_entry.op = m64h_pkg::OP_ABSORB_LAST;
      end else begin
         push_entry.op = m64h_pkg::OP_FINISH;
      end
   end

   // advance message tracking on each accepted word
   assign in_message_in = accept ? !req_last_word : in_message_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_message_ff <= 1'b0;
      end else begin
         in_message_ff <= in_message_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/m64h_queue.sv -----
// ----------------------------------------------------------------------------
// m64h_queue
// Small FIFO of classified words between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module m64h_queue #(
   parameter int DEPTH = m64h_pkg::QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_ready,
   input  wire m64h_pkg::entry_type push_entry,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output m64h_pkg::entry_type      pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   m64h_pkg::entry_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = entry_ff[rd_ptr_ff];

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/m64h_mul.sv -----
// ----------------------------------------------------------------------------
// m64h_mul
// Low 64 bits of a 64 by 64 product, built from three 32 by 32 partial
// products on one multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module m64h_mul (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire m64h_pkg::mul_req_type mul_req,
   output m64h_pkg::mul_rsp_type      mul_rsp
);

   typedef enum logic [1:0] {
      STEP_IDLE,
      STEP_LL,    // a_lo * b_lo
      STEP_HL,    // a_hi * b_lo, upper half only
      STEP_LH     // a_lo * b_hi, upper half only
   } step_type;

   step_type    step_ff, step_in;
   logic        done_ff, done_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] p_ff, p_in;
   logic [31:0] op_a;
   logic [31:0] op_b;
   logic [63:0] prod;

   // select the partial-product operands
   assign op_a = (step_ff == STEP_HL) ? a_ff[63:32] : a_ff[31:0];
   assign op_b = (step_ff == STEP_LH) ? b_ff[63:32] : b_ff[31:0];
   assign prod = op_a * op_b;

   // sequence the partial products
   always_comb begin
      step_in = step_ff;
      done_in = 1'b0;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      p_in    = p_ff;
      case (step_ff)
         STEP_IDLE: begin
            if (mul_req.start) begin
               a_in    = mul_req.a;
               b_in    = mul_req.b;
               step_in = STEP_LL;
            end
         end
         STEP_LL: begin
            acc_in  = prod;
            step_in = STEP_HL;
         end
         STEP_HL: begin
            acc_in  = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
            step_in = STEP_LH;
         end
         STEP_LH: begin
            p_in    = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
            done_in = 1'b1;
            step_in = STEP_IDLE;
         end
         default: begin
            step_in = STEP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      p_ff   <= p_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = p_ff;

endmodule

`default_nettype wire

// ----- rtl/m64h_back.sv -----
// ----------------------------------------------------------------------------
// m64h_back
// Sequencer that pops classified words, runs the finalizer mix and the
// rotate-multiply-add step on the shared multiplier, and holds the result
// word in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module m64h_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pop_valid,
   output logic                       pop_ready,
   input  wire m64h_pkg::entry_type   pop_entry,
   output m64h_pkg::mul_req_type      mul_req,
   input  wire m64h_pkg::mul_rsp_type mul_rsp,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [63:0]                rsp_hash_value
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX_A,
      ST_WAIT_A,
      ST_MIX_B,
      ST_WAIT_B,
      ST_STEP,
      ST_WAIT_STEP,
      ST_OUT
   } state_type;

   state_type   state_ff, state_in;
   logic [63:0] v_ff, v_in;          // value under the finalizer mix
   logic [63:0] h_ff, h_in;          // running hash
   logic        fin_ff, fin_in;      // mixing the running hash for output
   logic        tail_ff, tail_in;    // finish after this absorb
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_hash_ff, rsp_hash_in;

   logic [63:0] v_shx;
   logic [63:0] p_shx;
   logic [63:0] h_mix;
   logic [63:0] h_rot;
   logic [63:0] h_start;
   logic [63:0] h_sum;

   assign v_shx   = v_ff ^ (v_ff >> m64h_pkg::SHR_N);
   assign p_shx   = mul_rsp.product ^ (mul_rsp.product >> m64h_pkg::SHR_N);
   assign h_mix   = h_ff ^ p_shx;
   assign h_rot   = (h_mix << m64h_pkg::ROT_N) | (h_mix >> (64 - m64h_pkg::ROT_N));
   assign h_start = pop_entry.first ? (m64h_pkg::SEED ^ {32'd0, pop_entry.length}) : h_ff;
   assign h_sum   = mul_rsp.product + m64h_pkg::ADD_K;

   assign pop_ready = (state_ff == ST_IDLE);

   // sequence one word through the mix steps
   always_comb begin
      state_in     = state_ff;
      v_in         = v_ff;
      h_in         = h_ff;
      fin_in       = fin_ff;
      tail_in      = tail_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mul_req.start = 1'b0;
      mul_req.a     = v_shx;
      mul_req.b     = m64h_pkg::FMIX_A;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               case (pop_entry.op)
                  m64h_pkg::OP_EMPTY: begin
                     v_in     = m64h_pkg::SEED;
                     state_in = ST_OUT;
                  end
                  m64h_pkg::OP_FINISH: begin
                     v_in     = h_start;
                     h_in     = h_start;
                     fin_in   = 1'b1;
                     tail_in  = 1'b0;
                     state_in = ST_MIX_A;
                  end
                  m64h_pkg::OP_ABSORB_LAST: begin
                     v_in     = pop_entry.word;
                     h_in     = h_start;
                     fin_in   = 1'b0;
                     tail_in  = 1'b1;
                     state_in = ST_MIX_A;
                  end
                  default: begin
                     v_in     = pop_entry.word;
                     h_in     = h_start;
                     fin_in   = 1'b0;
                     tail_in  = 1'b0;
                     state_in = ST_MIX_A;
                  end
               endcase
            end
         end
         ST_MIX_A: begin
            mul_req.start = 1'b1;
            state_in      = ST_WAIT_A;
         end
         ST_WAIT_A: begin
            if (mul_rsp.done) begin
               v_in     = mul_rsp.product;
               state_in = ST_MIX_B;
            end
         end
         ST_MIX_B: begin
            mul_req.start = 1'b1;
            mul_req.b     = m64h_pkg::FMIX_B;
            state_in      = ST_WAIT_B;
         end
         ST_WAIT_B: begin
            if (mul_rsp.done) begin
               if (fin_ff) begin
                  v_in     = p_shx;
                  state_in = ST_OUT;
               end else begin
                  h_in     = h_rot;
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            mul_req.start = 1'b1;
            mul_req.a     = h_ff;
            mul_req.b     = m64h_pkg::MUL_K;
            state_in      = ST_WAIT_STEP;
         end
         ST_WAIT_STEP: begin
            if (mul_rsp.done) begin
               h_in = h_sum;
               if (tail_ff) begin
                  v_in     = h_sum;
                  fin_in   = 1'b1;
                  tail_in  = 1'b0;
                  state_in = ST_MIX_A;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = v_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fin_ff       <= 1'b0;
         tail_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fin_ff       <= fin_in;
         tail_ff      <= tail_in;
      end
      v_ff        <= v_in;
      h_ff        <= h_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule

`default_nettype wire

// ----- rtl/mix64_stream_hash_top.sv -----
// ----------------------------------------------------------------------------
// mix64_stream_hash_top
// 64-bit hash of a byte message streamed as 8-byte little-endian words.
// ----------------------------------------------------------------------------
// A message is sent as words with a byte count, a last flag and the total
// length (sampled on the first word); one hash word comes out per message.
// The front end masks and classifies each word into a queue; the back end
// runs every 64-bit multiply on one shared 32x32 multiplier, three partial
// products per multiply. A word before the last takes two finalizer
// multiplies and one rotate-multiply-add; a last word with data adds the
// final mix of two more multiplies, a zero-byte last word runs the final
// mix only and an empty message emits the bare seed. The queue lets the front keep
// accepting words while the back end works.
// ----------------------------------------------------------------------------
`default_nettype none

module mix64_stream_hash_top #(
   parameter int QUEUE_DEPTH = m64h_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_data_word,
   input  wire logic [3:0]  req_byte_count,
   input  wire logic        req_last_word,
   input  wire logic [31:0] req_message_length,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_hash_value
);

   logic                  push_valid;
   logic                  push_ready;
   m64h_pkg::entry_type   push_entry;
   logic                  pop_valid;
   logic                  pop_ready;
   m64h_pkg::entry_type   pop_entry;
   m64h_pkg::mul_req_type mul_req;
   m64h_pkg::mul_rsp_type mul_rsp;

   m64h_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_word      (req_data_word),
      .req_byte_count     (req_byte_count),
      .req_last_word      (req_last_word),
      .req_message_length (req_message_length),
      .push_valid         (push_valid),
      .push_ready         (push_ready),
      .push_entry         (push_entry)
   );

   m64h_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   m64h_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   m64h_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_entry      (pop_entry),
      .mul_req        (mul_req),
      .mul_rsp        (mul_rsp),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

`default_nettype wire

// ----- rtl/m64h_checker.sv -----
// ----------------------------------------------------------------------------
// m64h_checker
// Port-level checks of the stream hash: reset, output hold and result
// accounting against accepted last words.
// ----------------------------------------------------------------------------
`default_nettype none

module m64h_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_last_word,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_hash_value
);

   logic [7:0] pending_ff, pending_in;
   logic       last_accept;
   logic       rsp_accept;

   assign last_accept = req_valid && req_ready && req_last_word;
   assign rsp_accept  = rsp_valid && rsp_ready;

   // count messages ended but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (last_accept && !rsp_accept) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_accept && !last_accept) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // no result word right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word shown after reset");

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash_value))
      else $error("stalled result word changed or dropped");

   // every result word answers an accepted last word
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 8'd0)
      else $error("result word without a finished message");

   // a delivered result word leaves the owed count one lower
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && !last_accept |=> pending_ff == $past(pending_ff) - 8'd1)
      else $error("result accounting slipped");

endmodule

bind mix64_stream_hash_top m64h_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_last_word  (req_last_word),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hash_value (rsp_hash_value)
);

`default_nettype wire

// ----- verif/m64h_checker.sv -----
// ----------------------------------------------------------------------------
// m64h_tb_checker
// Watches both channels of the stream hash, predicts every hash word and
// compares it with the one the block returns.
// ----------------------------------------------------------------------------
// Each accepted input word advances a private copy of the message state.
// A last word or an empty message queues one expected hash. Each accepted
// result is compared with the oldest queued hash. Counts are handed to the
// top through registered outputs.
// ----------------------------------------------------------------------------

module m64h_tb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_byte_count,
   input  logic        req_last_word,
   input  logic [31:0] req_message_length,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [63:0] rsp_hash_value,
   output int          fail_count,
   output int          pending_count,
   output int          hashes_checked
);

   logic [63:0] model_hash;
   logic        model_busy;
   logic [63:0] expected_hashes[$];
   int          mismatches;
   int          checked;

   initial begin
      fail_count     = 0;
      pending_count  = 0;
      hashes_checked = 0;
      mismatches     = 0;
      checked        = 0;
      model_hash     = '0;
      model_busy     = 1'b0;
   end

   // 64-bit finalizer: shift-xor, multiply, shift-xor, multiply, shift-xor
   function automatic logic [63:0] final_mix(input logic [63:0] v);
      logic [63:0] m;
      m = v ^ (v >> m64h_pkg::SHR_N);
      m = m * m64h_pkg::FMIX_A;
      m = m ^ (m >> m64h_pkg::SHR_N);
      m = m * m64h_pkg::FMIX_B;
      m = m ^ (m >> m64h_pkg::SHR_N);
      return m;
   endfunction

   // fold one word into the running value
   function automatic logic [63:0] fold_word(input logic [63:0] h, input logic [63:0] w);
      logic [63:0] r;
      r = h ^ final_mix(w);
      r = {r[63-m64h_pkg::ROT_N:0], r[63:64-m64h_pkg::ROT_N]};
      r = r * m64h_pkg::MUL_K + m64h_pkg::ADD_K;
      return r;
   endfunction

   // advance the message state by one accepted word
   function void track_word(input logic [63:0] data, input logic [3:0] count,
                            input logic last, input logic [31:0] length);
      logic [3:0]  used;
      logic [63:0] w;
      used = (count > m64h_pkg::FULL_COUNT) ? m64h_pkg::FULL_COUNT : count;
      w    = data;
      if (!model_busy) begin
         if (last && length == 32'd0) begin
            model_hash = '0;
            expected_hashes.push_back(m64h_pkg::SEED);
            return;
         end
         model_hash = m64h_pkg::SEED ^ {32'd0, length};
      end
      if (!last) begin
         model_hash = fold_word(model_hash, w);
         model_busy = 1'b1;
      end else begin
         if (used != 4'd0) begin
            if (used < m64h_pkg::FULL_COUNT)
               w = w & ((64'd1 << (8 * used)) - 64'd1);
            model_hash = fold_word(model_hash, w);
         end
         expected_hashes.push_back(final_mix(model_hash));
         model_busy = 1'b0;
      end
   endfunction

   // sample both channels at the edge and compare results in order
   always @(posedge clock) begin : watch
      logic [63:0] want;
      if (reset) begin
         model_hash = '0;
         model_busy = 1'b0;
         expected_hashes.delete();
      end else begin
         if (req_valid && req_ready)
            track_word(req_data_word, req_byte_count, req_last_word, req_message_length);
         if (rsp_valid && rsp_ready) begin
            if (expected_hashes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] unexpected hash word %h", $realtime, rsp_hash_value);
            end else begin
               want = expected_hashes.pop_front();
               checked++;
               if (rsp_hash_value !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("[%0t] hash_value mismatch: expected %h, got %h",
                              $realtime, want, rsp_hash_value);
               end
            end
         end
      end
      fail_count     <= mismatches;
      pending_count  <= expected_hashes.size();
      hashes_checked <= checked;
   end

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the 64-bit word stream hash.
// ----------------------------------------------------------------------------
// Sends a directed set of corner messages, then random messages: mostly
// well-formed ones with random content and sizes, the rest noise with wild
// byte counts and lengths. Both sides idle at random; the receiver also holds
// off once for a long stretch so the queue fills. The checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------

module tb_top;

   localparam int RANDOM_WORDS = 1850;
   localparam int HOLD_START   = 2000;
   localparam int HOLD_CYCLES  = 700;
   localparam int CALM_START   = 9000;
   localparam int CALM_CYCLES  = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_data_word = '0;
   logic [3:0]  req_byte_count = '0;
   logic        req_last_word = 1'b0;
   logic [31:0] req_message_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_hash_value;

   int fail_count;
   int pending_count;
   int hashes_checked;
   int words_sent = 0;
   int messages_sent = 0;
   int rx_cycle = 0;
   bit steady_send = 1'b0;

   always #10 clock = ~clock;

   mix64_stream_hash_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_word      (req_data_word),
      .req_byte_count     (req_byte_count),
      .req_last_word      (req_last_word),
      .req_message_length (req_message_length),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hash_value     (rsp_hash_value)
   );

   m64h_tb_checker u_tb_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_word      (req_data_word),
      .req_byte_count     (req_byte_count),
      .req_last_word      (req_last_word),
      .req_message_length (req_message_length),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hash_value     (rsp_hash_value),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .hashes_checked     (hashes_checked)
   );

   // receiver: random stalls, one long hold-off, one stretch always ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
            rsp_ready <= 1'b0;
         else if (rx_cycle >= CALM_START && rx_cycle < CALM_START + CALM_CYCLES)
            rsp_ready <= 1'b1;
         else
            rsp_ready <= ($urandom_range(99) >= 16);
      end
   end

   // offer one word and hold it until accepted
   task automatic send_word(input logic [63:0] data, input logic [3:0] count,
                            input logic last, input logic [31:0] length);
      while (!steady_send && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data_word      <= data;
      req_byte_count     <= count;
      req_last_word      <= last;
      req_message_length <= length;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      if (last) messages_sent++;
   endtask

   function automatic logic [63:0] any_word();
      return {$urandom, $urandom};
   endfunction

   // well-formed message: full words, then a last word of 0..8 bytes
   task automatic send_clean_message();
      int nwords;
      int tail;
      logic [31:0] total;
      nwords = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
      tail   = $urandom_range(8);
      total  = 32'(8 * (nwords - 1) + tail);
      for (int i = 0; i < nwords - 1; i++)
         send_word(any_word(), m64h_pkg::FULL_COUNT, 1'b0, (i == 0) ? total : $urandom);
      send_word(any_word(), tail[3:0], 1'b1, (nwords == 1) ? total : $urandom);
   endtask

   // noisy message: wild byte counts and lengths
   task automatic send_noisy_message();
      int nwords;
      logic [31:0] length;
      nwords = $urandom_range(4, 1);
      for (int i = 0; i < nwords; i++) begin
         length = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
         send_word(any_word(), 4'($urandom_range(15)), i == nwords - 1, length);
      end
   endtask

   initial begin
      int first_random;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty messages, data ignored
      send_word('1, 4'd0, 1'b1, 32'd0);
      send_word(any_word(), m64h_pkg::FULL_COUNT, 1'b1, 32'd0);
      // single full words at the data extremes
      send_word('1, m64h_pkg::FULL_COUNT, 1'b1, 32'd8);
      send_word('0, m64h_pkg::FULL_COUNT, 1'b1, 32'd8);
      // short last words, upper bytes masked
      for (int c = 1; c < 8; c++)
         send_word('1, 4'(c), 1'b1, 32'(c));
      // byte count over eight on a last word
      send_word('1, 4'd15, 1'b1, 32'd8);
      // word before the last with a short count, then a zero-byte last word
      send_word(any_word(), 4'd3, 1'b0, 32'd8);
      send_word('1, 4'd0, 1'b1, 32'd0);
      // zero length in a longer message; later length is not sampled
      send_word(any_word(), m64h_pkg::FULL_COUNT, 1'b0, 32'd0);
      send_word(any_word(), 4'd5, 1'b1, 32'hffff_ffff);
      // length that disagrees with the bytes delivered
      send_word(any_word(), 4'd4, 1'b1, 32'hffff_ffff);
      // oversized count before the last, top length bits set
      send_word('1, 4'd12, 1'b0, 32'h8000_0010);
      send_word('0, m64h_pkg::FULL_COUNT, 1'b1, 32'd0);

      // random part, with one stretch of back-to-back words
      first_random = words_sent;
      while (words_sent - first_random < RANDOM_WORDS) begin
         steady_send = (words_sent - first_random >= 800) &&
                       (words_sent - first_random < 1100);
         if ($urandom_range(99) < 80)
            send_clean_message();
         else
            send_noisy_message();
      end
      steady_send = 1'b0;
      req_valid <= 1'b0;
      @(posedge clock);

      // drain outstanding hashes, then let the back end settle
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Sent %0d words in %0d messages; %0d hash words compared.",
               words_sent, messages_sent, hashes_checked);
      $display("Covered empty, short, zero-byte and oversized-count words plus a long stall.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d hashes still outstanding", fail_count, pending_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("Timed out with %0d hashes outstanding", pending_count);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/m64h_pkg.sv
rtl/m64h_front.sv
rtl/m64h_queue.sv
rtl/m64h_mul.sv
rtl/m64h_back.sv
rtl/mix64_stream_hash_top.sv
rtl/m64h_checker.sv
verif/m64h_checker.sv
verif/tb_top.sv
